// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the escaper modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants of the JSON string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_CHAR = 3'd1;
   localparam logic [2:0] KIND_ESC2 = 3'd2;
   localparam logic [2:0] KIND_HEX1 = 3'd3;
   localparam logic [2:0] KIND_HEX2 = 3'd4;

   localparam logic [6:0] CH_QUOTE  = 7'h22;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_U      = 7'h75;

   localparam int        MAX_CHARS = 12;
   localparam int        LEN_W     = 4;
   localparam int        HEX_CHARS = 6;

   localparam int        FIFO_DEPTH = 4;
   localparam int        FIFO_PTR_W = 2;
   localparam int        FIFO_CNT_W = 3;

   // one item's worth of output, as decided by the front end
   typedef struct packed {
      logic             flush_vld;
      logic [7:0]       flush_val;
      logic [2:0]       kind;
      logic [6:0]       ch;
      logic [15:0]      hex_a;
      logic [15:0]      hex_b;
      logic [LEN_W-1:0] len;
   } job_type;

endpackage

`default_nettype wire

// File: rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accepts items, tracks UTF-8 decode state and builds at most one output job per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module jse_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic [1:0]       req_cmd,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             fifo_full,
   output jse_pkg::job_type      job,
   output logic                  job_push
);

   logic [20:0] pcp_ff, pcp_in;
   logic [1:0]  exp_ff, exp_in;
   logic [7:0]  lead_ff, lead_in;

   logic        accept;
   logic        pend;
   logic [20:0] pcp_next;
   logic [20:0] v;
   logic [3:0]  main_len;
   jse_pkg::job_type j;

   assign accept = req_push && !fifo_full;
   assign pend   = (exp_ff != 2'd0);
   assign pcp_next = {pcp_ff[14:0], req_data_byte[5:0]};
   assign v = pcp_next - 21'h10000;

   always_comb begin
      j           = '0;
      j.kind      = jse_pkg::KIND_NONE;
      j.flush_val = lead_ff;
      pcp_in      = pcp_ff;
      exp_in      = exp_ff;
      lead_in     = lead_ff;
      case (req_cmd)
         jse_pkg::CMD_BEGIN, jse_pkg::CMD_END: begin
            j.flush_vld = pend;
            j.kind      = jse_pkg::KIND_CHAR;
            j.ch        = jse_pkg::CH_QUOTE;
            pcp_in      = '0;
            exp_in      = 2'd0;
         end
         jse_pkg::CMD_DATA: begin
            if (pend && req_data_byte[7:6] == 2'b10) begin
               exp_in = exp_ff - 2'd1;
               if (exp_ff == 2'd1) begin
                  pcp_in = '0;
                  if (pcp_next[20:16] == 5'd0) begin
                     j.kind  = jse_pkg::KIND_HEX1;
                     j.hex_a = pcp_next[15:0];
                  end else begin
                     j.kind  = jse_pkg::KIND_HEX2;
                     j.hex_a = 16'hD800 + {5'd0, v[20:10]};
                     j.hex_b = 16'hDC00 + {6'd0, v[9:0]};
                  end
               end else begin
                  pcp_in = pcp_next;
               end
            end else begin
               j.flush_vld = pend;
               pcp_in      = '0;
               exp_in      = 2'd0;
               case (req_data_byte)
                  8'h22: begin j.kind = jse_pkg::KIND_ESC2; j.ch = jse_pkg::CH_QUOTE; end
                  8'h5C: begin j.kind = jse_pkg::KIND_ESC2; j.ch = jse_pkg::CH_BSLASH; end
                  8'h08: begin j.kind = jse_pkg::KIND_ESC2; j.ch = 7'h62; end
                  8'h0C: begin j.kind = jse_pkg::KIND_ESC2; j.ch = 7'h66; end
                  8'h0A: begin j.kind = jse_pkg::KIND_ESC2; j.ch = 7'h6E; end
                  8'h0D: begin j.kind = jse_pkg::KIND_ESC2; j.ch = 7'h72; end
                  8'h09: begin j.kind = jse_pkg::KIND_ESC2; j.ch = 7'h74; end
                  default: begin
                     if (req_data_byte < 8'h20) begin
                        j.kind  = jse_pkg::KIND_HEX1;
                        j.hex_a = {8'h00, req_data_byte};
                     end else if (req_data_byte < 8'h80) begin
                        j.kind = jse_pkg::KIND_CHAR;
                        j.ch   = req_data_byte[6:0];
                     end else if (req_data_byte[7:5] == 3'b110) begin
                        pcp_in  = {16'd0, req_data_byte[4:0]};
                        exp_in  = 2'd1;
                        lead_in = req_data_byte;
                     end else if (req_data_byte[7:4] == 4'b1110) begin
                        pcp_in  = {17'd0, req_data_byte[3:0]};
                        exp_in  = 2'd2;
                        lead_in = req_data_byte;
                     end else if (req_data_byte[7:3] == 5'b11110) begin
                        pcp_in  = {18'd0, req_data_byte[2:0]};
                        exp_in  = 2'd3;
                        lead_in = req_data_byte;
                     end else begin
                        j.kind  = jse_pkg::KIND_HEX1;
                        j.hex_a = {8'h00, req_data_byte};
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      case (j.kind)
         jse_pkg::KIND_CHAR: main_len = 4'd1;
         jse_pkg::KIND_ESC2: main_len = 4'd2;
         jse_pkg::KIND_HEX1: main_len = 4'd6;
         jse_pkg::KIND_HEX2: main_len = 4'd12;
         default:            main_len = 4'd0;
      endcase
      j.len = main_len + (j.flush_vld ? jse_pkg::LEN_W'(jse_pkg::HEX_CHARS) : 4'd0);
   end

   assign job      = j;
   assign job_push = accept && (j.len != 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pcp_ff  <= '0;
         exp_ff  <= 2'd0;
         lead_ff <= '0;
      end else if (accept) begin
         pcp_ff  <= pcp_in;
         exp_ff  <= exp_in;
         lead_ff <= lead_in;
      end
   end

   `ASSERT_IMPLY(a_idle_clear, clock, reset, exp_ff == 2'd0, pcp_ff == 21'd0)
   `ASSERT_IMPLY(a_job_len, clock, reset, job_push, job.len <= jse_pkg::LEN_W'(jse_pkg::MAX_CHARS))

endmodule

`default_nettype wire

// File: rtl/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// Short job queue between the front end and the character serializer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module jse_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire jse_pkg::job_type push_job,
   output logic                  full,
   output logic                  head_vld,
   output jse_pkg::job_type      head_job,
   input  wire logic             pop
);

   jse_pkg::job_type                   slot_ff [jse_pkg::FIFO_DEPTH];
   logic [jse_pkg::FIFO_PTR_W-1:0]     wr_ff, wr_in;
   logic [jse_pkg::FIFO_PTR_W-1:0]     rd_ff, rd_in;
   logic [jse_pkg::FIFO_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                               do_push, do_pop;

   assign full     = (cnt_ff == jse_pkg::FIFO_CNT_W'(jse_pkg::FIFO_DEPTH));
   assign head_vld = (cnt_ff != '0);
   assign head_job = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && head_vld;

   always_comb begin
      wr_in  = do_push ? wr_ff + jse_pkg::FIFO_PTR_W'(1'b1) : wr_ff;
      rd_in  = do_pop ? rd_ff + jse_pkg::FIFO_PTR_W'(1'b1) : rd_ff;
      cnt_in = cnt_ff + jse_pkg::FIFO_CNT_W'(do_push) - jse_pkg::FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   `ASSERT_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= jse_pkg::FIFO_CNT_W'(jse_pkg::FIFO_DEPTH))
   `ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push && full))

endmodule

`default_nettype wire

// File: rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expands queued jobs into characters, one per cycle while rsp_pop keeps up, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module jse_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_vld,
   input  wire jse_pkg::job_type head_job,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [6:0]            rsp_out_char,
   output logic                  rsp_last
);

   logic [jse_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic                      vld_ff, vld_in;
   logic [6:0]                char_ff, char_in;
   logic                      last_ff, last_in;
   logic                      load;
   logic [jse_pkg::LEN_W-1:0] rel;

   function automatic logic [6:0] hex_digit(input logic [3:0] d);
      hex_digit = (d < 4'd10) ? (7'h30 + {3'd0, d}) : (7'h57 + {3'd0, d});
   endfunction

   // k-th character of a \uXXXX group
   function automatic logic [6:0] hex_group(input logic [15:0] v,
                                           input logic [jse_pkg::LEN_W-1:0] k);
      case (k)
         4'd0:    hex_group = jse_pkg::CH_BSLASH;
         4'd1:    hex_group = jse_pkg::CH_U;
         4'd2:    hex_group = hex_digit(v[15:12]);
         4'd3:    hex_group = hex_digit(v[11:8]);
         4'd4:    hex_group = hex_digit(v[7:4]);
         default: hex_group = hex_digit(v[3:0]);
      endcase
   endfunction

   assign load = head_vld && (!vld_ff || rsp_pop);
   assign rel  = head_job.flush_vld ? (idx_ff - 4'd6) : idx_ff;

   always_comb begin
      if (head_job.flush_vld && idx_ff < 4'd6) begin
         char_in = hex_group({8'h00, head_job.flush_val}, idx_ff);
      end else begin
         case (head_job.kind)
            jse_pkg::KIND_ESC2: char_in = (rel == 4'd0) ? jse_pkg::CH_BSLASH : head_job.ch;
            jse_pkg::KIND_HEX1: char_in = hex_group(head_job.hex_a, rel);
            jse_pkg::KIND_HEX2: char_in = (rel < 4'd6) ? hex_group(head_job.hex_a, rel)
                                                       : hex_group(head_job.hex_b, rel - 4'd6);
            default:            char_in = head_job.ch;
         endcase
      end
      last_in  = (idx_ff == head_job.len - 4'd1);
      head_pop = load && last_in;
      idx_in   = load ? (last_in ? '0 : idx_ff + 4'd1) : idx_ff;
      vld_in   = load ? 1'b1 : (rsp_pop ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_empty    = !vld_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last     = last_ff;

   `ASSERT_ALWAYS(a_idx_range, clock, reset, idx_ff < 4'd12)
   `ASSERT_IMPLY(a_idx_idle, clock, reset, !head_vld, idx_ff == 4'd0)

endmodule

`default_nettype wire

// File: rtl/json_string_escaper_utf8.sv
// ----------------------------------------------------------------------------
// json_string_escaper_utf8
// UTF-8 byte stream to ASCII JSON string literal, one character per item out.
// ----------------------------------------------------------------------------
//   channel   ports                         handshake
//   request   req_cmd, req_data_byte        req_push / req_full
//   response  rsp_out_char, rsp_last        rsp_empty / rsp_pop
//
// An input item is taken whenever the 4-entry job queue has room.
// The serializer emits one character per cycle while rsp_pop keeps up, so an
// item expands to 0 to 12 output characters; with rsp_pop held high, plain ASCII runs at
// one item per cycle. The first character passes through the job queue and
// then the output register before it reaches the result ports.
// Synchronous reset clears decode state, queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper_utf8 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [6:0]       rsp_out_char,
   output logic             rsp_last
);

   jse_pkg::job_type push_job, head_job;
   logic             job_push, fifo_full, head_vld, head_pop;

   assign req_full = fifo_full;

   jse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .fifo_full     (fifo_full),
      .job           (push_job),
      .job_push      (job_push)
   );

   jse_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (fifo_full),
      .head_vld (head_vld),
      .head_job (head_job),
      .pop      (head_pop)
   );

   jse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_vld     (head_vld),
      .head_job     (head_job),
      .head_pop     (head_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire
